@@ sv/uvf_pkg.sv @@
// Package for the UTF-8 validate/filter block: shared types, codes and
// value limits. No dependencies.
package uvf_pkg;

    localparam int MAX_RESULTS = 4;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_FILTER_MODE = 1'b0;
    localparam logic REG_REPLACEMENT = 1'b1;

    localparam logic [7:0] REPLACEMENT_RESET = 8'd95;

    // Code point limits
    localparam logic [20:0] CP_MIN2       = 21'h000080;
    localparam logic [20:0] CP_MIN3       = 21'h000800;
    localparam logic [20:0] CP_MIN4       = 21'h010000;
    localparam logic [20:0] CP_LIMIT      = 21'h110000;
    localparam logic [20:0] SURR_MASK     = 21'h1FF800;
    localparam logic [20:0] SURR_BASE     = 21'h00D800;
    localparam logic [20:0] NONCHAR_LO    = 21'h00FDD0;
    localparam logic [20:0] NONCHAR_HI    = 21'h00FDEF;
    localparam logic [20:0] NONCHAR_MASK  = 21'h00FFFE;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic  filter_mode;
        t_byte replacement_byte;
    } t_cfg;

    typedef struct packed {
        t_byte out_byte;
        logic  end_of_string;
        logic  string_valid;
    } t_result;

    // Results caused by one input word, item[0] first
    typedef struct packed {
        logic [2:0]                      count;
        t_result [MAX_RESULTS-1:0]       item;
    } t_group;

endpackage

@@ sv/uvf_if.sv @@
// Handshake channels of the UTF-8 validate/filter block.
// Input word channel and result word channel; no dependencies.
interface uvf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source(output valid, output in_byte, input ready);
    modport sink(input valid, input in_byte, output ready);
endinterface

interface uvf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_string;
    logic       string_valid;

    modport source(output valid, output out_byte, output end_of_string,
                   output string_valid, input ready);
    modport sink(input valid, input out_byte, input end_of_string,
                 input string_valid, output ready);
endinterface

@@ sv/uvf_step.sv @@
// Sequence tracker of the UTF-8 validate/filter block: holds the pending
// sequence and builds the result group of each accepted word. Uses uvf_pkg.
module uvf_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  uvf_pkg::t_byte i_byte,
    input  uvf_pkg::t_cfg  i_cfg,
    output uvf_pkg::t_group o_group
);
    import uvf_pkg::*;

    t_byte       r_held [3];
    logic [1:0]  r_cnt;
    logic [2:0]  r_len;
    logic [20:0] r_cp;
    logic        r_err;

    t_byte       n_held [3];
    logic [1:0]  n_cnt;
    logic [2:0]  n_len;
    logic [20:0] n_cp;
    logic        n_err;

    logic        pending, is_cont, complete, grow, fresh, broken, ok, err_eff;
    logic        lead2, lead3, lead4, is_lead;
    logic [20:0] cp_new;
    logic [2:0]  cnt_ext, brk_n, len_clip;
    logic        fr_emit, fr_eos, fr_valid;
    t_byte       fr_data;
    t_byte       held4 [4];

    function automatic logic value_ok(input logic [20:0] v, input logic [2:0] len);
        logic [20:0] lo;
        begin
            case (len)
                3'd2:    lo = CP_MIN2;
                3'd3:    lo = CP_MIN3;
                default: lo = CP_MIN4;
            endcase
            value_ok = (v >= lo) && (v < CP_LIMIT)
                    && ((v & SURR_MASK) != SURR_BASE)
                    && !((v >= NONCHAR_LO) && (v <= NONCHAR_HI))
                    && ((v & NONCHAR_MASK) != NONCHAR_MASK);
        end
    endfunction

    // Classify the word against the pending sequence
    always_comb begin
        pending  = (r_len != 3'd0) && (r_cnt != 2'd0);
        is_cont  = (i_byte[7:6] == 2'b10);
        cp_new   = {r_cp[14:0], i_byte[5:0]};
        cnt_ext  = {1'b0, r_cnt};
        complete = pending && is_cont && ((cnt_ext + 3'd1) >= r_len);
        grow     = pending && is_cont && !complete;
        broken   = pending && !is_cont;
        fresh    = !(pending && is_cont);
        ok       = value_ok(cp_new, r_len);
        err_eff  = r_err | broken;
        lead2    = (i_byte[7:5] == 3'b110);
        lead3    = (i_byte[7:4] == 4'b1110);
        lead4    = (i_byte[7:3] == 5'b11110);
        is_lead  = lead2 | lead3 | lead4;
        len_clip = (r_len > 3'd4) ? 3'd4 : r_len;
        brk_n    = (broken && i_cfg.filter_mode) ? cnt_ext : 3'd0;
        held4[0] = r_held[0];
        held4[1] = r_held[1];
        held4[2] = r_held[2];
        held4[3] = i_byte;
    end

    // Result of parsing the word as the start of something new
    always_comb begin
        fr_emit  = 1'b0;
        fr_data  = i_byte;
        fr_eos   = 1'b0;
        fr_valid = 1'b0;
        if (i_byte == 8'd0) begin
            fr_emit  = 1'b1;
            fr_eos   = 1'b1;
            fr_valid = !err_eff;
        end else if (!i_byte[7]) begin
            fr_emit = i_cfg.filter_mode;
        end else if (!is_lead) begin
            fr_emit = i_cfg.filter_mode;
            fr_data = i_cfg.replacement_byte;
        end
    end

    // Build the result group
    always_comb begin
        o_group.count = 3'd0;
        if (complete) begin
            if (i_cfg.filter_mode) begin
                o_group.count = ok ? (cnt_ext + 3'd1) : len_clip;
            end
        end else if (fresh) begin
            o_group.count = brk_n + {2'b00, fr_emit};
        end
        for (int i = 0; i < MAX_RESULTS; i++) begin
            o_group.item[i].end_of_string = 1'b0;
            o_group.item[i].string_valid  = 1'b0;
            if (complete) begin
                if (!ok) begin
                    o_group.item[i].out_byte = i_cfg.replacement_byte;
                end else if (3'(i) < cnt_ext) begin
                    o_group.item[i].out_byte = held4[i];
                end else begin
                    o_group.item[i].out_byte = i_byte;
                end
            end else if (3'(i) < brk_n) begin
                o_group.item[i].out_byte = i_cfg.replacement_byte;
            end else begin
                o_group.item[i].out_byte      = fr_data;
                o_group.item[i].end_of_string = fr_eos;
                o_group.item[i].string_valid  = fr_valid;
            end
        end
    end

    // Next sequence state
    always_comb begin
        n_held = r_held;
        n_cnt  = r_cnt;
        n_len  = r_len;
        n_cp   = r_cp;
        n_err  = r_err;
        if (i_accept) begin
            if (complete) begin
                n_cnt = 2'd0;
                n_len = 3'd0;
                n_cp  = 21'd0;
                n_err = r_err | !ok;
            end else if (grow) begin
                if (r_cnt != 2'd3) begin
                    n_held[r_cnt] = i_byte;
                end
                n_cnt = r_cnt + 2'd1;
                n_cp  = cp_new;
            end else begin
                // drop the pending sequence, then parse afresh
                n_cnt = 2'd0;
                n_len = 3'd0;
                n_cp  = 21'd0;
                n_err = err_eff;
                if (i_byte == 8'd0) begin
                    n_err = 1'b0;
                end else if (!i_byte[7]) begin
                    n_err = err_eff;
                end else if (is_lead) begin
                    n_held[0] = i_byte;
                    n_cnt     = 2'd1;
                    if (lead2) begin
                        n_len = 3'd2;
                        n_cp  = {16'd0, i_byte[4:1], 1'b0};
                    end else if (lead3) begin
                        n_len = 3'd3;
                        n_cp  = {17'd0, i_byte[3:0]};
                    end else begin
                        n_len = 3'd4;
                        n_cp  = {18'd0, i_byte[2:0]};
                    end
                end else begin
                    n_err = 1'b1;
                end
            end
        end
    end

    // Held bytes carry no reset
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_len <= 3'd0;
            r_cp  <= 21'd0;
            r_err <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_len <= n_len;
            r_cp  <= n_cp;
            r_err <= n_err;
        end
    end

    a_len_cnt_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len == 3'd0) == (r_cnt == 2'd0))
        else $error("sequence length and held count disagree");

    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != 3'd0) |-> ((cnt_ext < r_len) && (r_len >= 3'd2) && (r_len <= 3'd4)))
        else $error("held count not below sequence length");

    a_group_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> (o_group.count <= 3'(MAX_RESULTS)))
        else $error("result group larger than four words");

endmodule

@@ sv/uvf_queue.sv @@
// Result queue of the UTF-8 validate/filter block: takes up to four
// words per cycle, releases one per cycle while i_ready is high. Uses uvf_pkg.
module uvf_queue #(
    parameter int DEPTH = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  uvf_pkg::t_group i_group,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output uvf_pkg::t_result o_result
);
    import uvf_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 1;

    t_result            r_mem [DEPTH];
    logic [ADDR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;

    logic [ADDR_W-1:0]  n_wr, n_rd;
    logic [CNT_W-1:0]   n_count;
    logic [2:0]         push_n;
    logic               pop;

    // Advance a slot index by up to four, wrapping at DEPTH
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [2:0] step);
        logic [SUM_W-1:0] sum;
        begin
            sum = SUM_W'(base) + SUM_W'(step);
            if (sum >= SUM_W'(DEPTH)) begin
                sum = sum - SUM_W'(DEPTH);
            end
            wrap_add = sum[ADDR_W-1:0];
        end
    endfunction

    assign push_n   = i_push ? i_group.count : 3'd0;
    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd];
    assign o_room   = (r_count <= CNT_W'(DEPTH - MAX_RESULTS));

    always_comb begin
        n_wr    = wrap_add(r_wr, push_n);
        n_rd    = pop ? wrap_add(r_rd, 3'd1) : r_rd;
        n_count = r_count + CNT_W'(push_n) - CNT_W'(pop);
    end

    // Write the group into consecutive slots
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (3'(k) < push_n) begin
                r_mem[wrap_add(r_wr, 3'(k))] <= i_group.item[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n != 3'd0) |-> o_room)
        else $error("group pushed without room");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && push_n == 3'd0) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("queue count lost a pop");

endmodule

@@ sv/utf8_validate_filter_top.sv @@
// Results of an accepted word go into the result queue. Throughput: one input word per
// cycle while the result queue has room for four words; results leave one per cycle while
// the receiver is ready, so a byte that yields several results stalls input later.
// Reset (i_rst_n, synchronous): empties the queue, drops any pending sequence and the
// error flag, sets filter mode off and the replacement byte to 95. No clearing pass.
module utf8_validate_filter_top #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uvf_in_if.sink      i_in,
    uvf_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uvf_pkg::*;

    t_cfg    r_cfg;
    t_cfg    n_cfg;
    t_group  group;
    t_result result;
    logic    room, accept, cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes
    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            case (paddr[2])
                REG_FILTER_MODE: n_cfg.filter_mode      = pwdata[0];
                REG_REPLACEMENT: n_cfg.replacement_byte = pwdata[7:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_mode      <= 1'b0;
            r_cfg.replacement_byte <= REPLACEMENT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Register reads
    always_comb begin
        case (paddr[2])
            REG_FILTER_MODE: prdata = {31'd0, r_cfg.filter_mode};
            REG_REPLACEMENT: prdata = {24'd0, r_cfg.replacement_byte};
            default:         prdata = 32'd0;
        endcase
    end

    // Accept a word whenever the queue can take a full group
    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    uvf_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .i_cfg    (r_cfg),
        .o_group  (group)
    );

    uvf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_group  (group),
        .o_room   (room),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (result)
    );

    assign o_out.out_byte      = result.out_byte;
    assign o_out.end_of_string = result.end_of_string;
    assign o_out.string_valid  = result.string_valid;

endmodule

@@ bench/tb_utf8_validate_filter_top.sv @@
// Self-checking bench for utf8_validate_filter_top: directed table, then random
// UTF-8 token streams under several register settings, all checked word by word.
// Depends on uvf_pkg (sv/uvf_pkg.sv) and the channel interfaces (sv/uvf_if.sv).
module tb_utf8_validate_filter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import uvf_pkg::*;

    localparam int WATCHDOG_LIMIT = 1500;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int LONG_HOLD      = 160;
    localparam int PHASE_BYTES    = 48;
    localparam int NUM_PHASES     = 4;

    localparam logic [2:0] ADDR_FILTER_MODE = {REG_FILTER_MODE, 2'b00};
    localparam logic [2:0] ADDR_REPLACEMENT = {REG_REPLACEMENT, 2'b00};

    typedef enum logic {ROW_BYTE, ROW_MODE} t_row_kind;

    // One byte to send; a typed row carries its expected words by hand
    typedef struct {
        t_byte      value;
        bit         typed;
        logic [2:0] want_cnt;
        t_result    want;
    } t_job;

    typedef struct {
        t_row_kind kind;
        t_job      job;
    } t_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    uvf_in_if  in_ch();
    uvf_out_if out_ch();

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
    end

    utf8_validate_filter_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    // Stimulus and expectation stores
    t_job    job_q[$];
    t_job    on_bus[$];
    t_result due_words[$];

    // Decoder mirror and register mirror
    t_cfg        cfg_live;
    t_byte       pd_held[3];
    logic [1:0]  pd_cnt;
    logic [2:0]  pd_len;
    logic [20:0] pd_cp;
    logic        pd_err;

    int fails       = 0;
    int n_bytes_in  = 0;
    int n_words_out = 0;
    int n_terms     = 0;
    int idle_cycles = 0;
    int holds_asked = 0;
    int holds_done  = 0;

    // ------------------------------------------------------------------
    // Decoder mirror
    // ------------------------------------------------------------------
    function automatic void add_word(inout t_group g, input t_byte b, input logic eos,
                                     input logic ok);
        if (int'(g.count) < MAX_RESULTS) begin
            g.item[g.count] = '{out_byte: b, end_of_string: eos, string_valid: ok};
            g.count = g.count + 3'd1;
        end
    endfunction

    function automatic bit cp_acceptable(logic [20:0] v, logic [2:0] n);
        logic [20:0] floor_v;
        floor_v = (n == 3'd2) ? CP_MIN2 : (n == 3'd3) ? CP_MIN3 : CP_MIN4;
        if (v < floor_v) return 1'b0;
        if (v >= CP_LIMIT) return 1'b0;
        if ((v & SURR_MASK) == SURR_BASE) return 1'b0;
        if (v >= NONCHAR_LO && v <= NONCHAR_HI) return 1'b0;
        if ((v & NONCHAR_MASK) == NONCHAR_MASK) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void drop_seq();
        pd_cnt = '0;
        pd_len = '0;
        pd_cp  = '0;
    endfunction

    // Parse a byte with no sequence pending
    function automatic void start_fresh(input t_byte b, inout t_group g);
        if (b == 8'h00) begin
            add_word(g, 8'h00, 1'b1, !pd_err);
            pd_err = 1'b0;
        end else if (b[7] == 1'b0) begin
            if (cfg_live.filter_mode) add_word(g, b, 1'b0, 1'b0);
        end else if (b[7:5] == 3'b110) begin
            pd_held[0] = b;
            pd_cnt = 2'd1;
            pd_len = 3'd2;
            pd_cp  = {16'd0, b[4:1], 1'b0};
        end else if (b[7:4] == 4'b1110) begin
            pd_held[0] = b;
            pd_cnt = 2'd1;
            pd_len = 3'd3;
            pd_cp  = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            pd_held[0] = b;
            pd_cnt = 2'd1;
            pd_len = 3'd4;
            pd_cp  = {18'd0, b[2:0]};
        end else begin
            pd_err = 1'b1;
            if (cfg_live.filter_mode) add_word(g, cfg_live.replacement_byte, 1'b0, 1'b0);
        end
    endfunction

    // Advance the mirror by one accepted byte, return the words it causes
    function automatic void decode_byte(input t_byte b, output t_group g);
        g = '0;
        if (pd_len == 3'd0 || pd_cnt == 2'd0) begin
            drop_seq();
            start_fresh(b, g);
            return;
        end
        if (b[7:6] == 2'b10) begin
            pd_cp = {pd_cp[14:0], b[5:0]};
            if (int'(pd_cnt) + 1 >= int'(pd_len)) begin
                if (cp_acceptable(pd_cp, pd_len)) begin
                    if (cfg_live.filter_mode) begin
                        for (int i = 0; i < int'(pd_cnt); i++)
                            add_word(g, pd_held[i], 1'b0, 1'b0);
                        add_word(g, b, 1'b0, 1'b0);
                    end
                end else begin
                    pd_err = 1'b1;
                    if (cfg_live.filter_mode)
                        for (int i = 0; i < int'(pd_len); i++)
                            add_word(g, cfg_live.replacement_byte, 1'b0, 1'b0);
                end
                drop_seq();
            end else begin
                pd_held[pd_cnt] = b;
                pd_cnt = pd_cnt + 2'd1;
            end
            return;
        end
        // Broken sequence: replace held bytes, then reparse the breaking byte
        pd_err = 1'b1;
        if (cfg_live.filter_mode)
            for (int i = 0; i < int'(pd_cnt); i++)
                add_word(g, cfg_live.replacement_byte, 1'b0, 1'b0);
        drop_seq();
        start_fresh(b, g);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic t_row typed_row(t_byte b, logic [2:0] n, t_byte ob, logic eos,
                                       logic ok);
        t_row r;
        r.kind = ROW_BYTE;
        r.job  = '{value: b, typed: 1'b1, want_cnt: n,
                   want: '{out_byte: ob, end_of_string: eos, string_valid: ok}};
        return r;
    endfunction

    function automatic t_row plain_row(t_byte b);
        t_row r;
        r.kind = ROW_BYTE;
        r.job  = '{value: b, typed: 1'b0, want_cnt: 3'd0, want: '0};
        return r;
    endfunction

    function automatic t_row mode_row(t_byte v);
        t_row r;
        r = plain_row(v);
        r.kind = ROW_MODE;
        return r;
    endfunction

    function automatic void push_byte(t_byte b);
        job_q.push_back('{value: b, typed: 1'b0, want_cnt: 3'd0, want: '0});
    endfunction

    // Encode a value in n bytes; small values give overlong forms
    function automatic void emit_cp(logic [20:0] cp, int n);
        case (n)
            2: begin
                push_byte({3'b110, cp[10:6]});
                push_byte({2'b10, cp[5:0]});
            end
            3: begin
                push_byte({4'b1110, cp[15:12]});
                push_byte({2'b10, cp[11:6]});
                push_byte({2'b10, cp[5:0]});
            end
            default: begin
                push_byte({5'b11110, cp[20:18]});
                push_byte({2'b10, cp[17:12]});
                push_byte({2'b10, cp[11:6]});
                push_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Append one random token: mostly whole sequences, some noise and breaks
    function automatic void gen_token();
        int          pick;
        int          n;
        int          k;
        logic [20:0] cp;
        logic [4:0]  plane;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            push_byte(t_byte'($urandom_range(1, 127)));
        end else if (pick < 55) begin
            n = $urandom_range(2, 4);
            case (n)
                2:       cp = 21'($urandom_range(32'h80, 32'h7FF));
                3:       cp = 21'($urandom_range(32'h800, 32'hFFFF));
                default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
            endcase
            emit_cp(cp, n);
        end else if (pick < 70) begin
            case ($urandom_range(0, 5))
                0: emit_cp(SURR_BASE + 21'($urandom_range(0, 32'h7FF)), 3);
                1: emit_cp(NONCHAR_LO + 21'($urandom_range(0, 31)), 3);
                2: begin
                    plane = 5'($urandom_range(0, 16));
                    cp = {plane, 16'hFFFE} | 21'($urandom_range(0, 1));
                    emit_cp(cp, (plane == 5'd0) ? 3 : 4);
                end
                3: begin
                    n = $urandom_range(3, 4);
                    cp = 21'($urandom_range(0, (n == 3) ? 32'h7FF : 32'hFFFF));
                    emit_cp(cp, n);
                end
                4: emit_cp(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
                default: begin
                    // C0 / C1 lead
                    push_byte({7'b1100000, 1'($urandom_range(0, 1))});
                    push_byte({2'b10, 6'($urandom)});
                end
            endcase
        end else if (pick < 80) begin
            // Broken sequence: lead, too few continuations, then a breaker
            n = $urandom_range(2, 4);
            case (n)
                2:       push_byte({3'b110, 5'($urandom)});
                3:       push_byte({4'b1110, 4'($urandom)});
                default: push_byte({5'b11110, 3'($urandom)});
            endcase
            k = $urandom_range(0, n - 2);
            repeat (k) push_byte({2'b10, 6'($urandom)});
            case ($urandom_range(0, 3))
                0:       push_byte(t_byte'($urandom_range(1, 127)));
                1:       push_byte(t_byte'($urandom_range(8'hC0, 8'hF7)));
                2:       push_byte(8'h00);
                default: push_byte(t_byte'($urandom_range(8'hF8, 8'hFF)));
            endcase
        end else if (pick < 90) begin
            push_byte(t_byte'($urandom_range(1, 255)));
        end else begin
            push_byte(8'h00);
        end
    endfunction

    // ------------------------------------------------------------------
    // Channel and register drivers
    // ------------------------------------------------------------------
    // Offer queued bytes in bursts of random length with random gaps
    task automatic send_jobs();
        int   burst;
        int   gap;
        t_job j;
        burst = 0;
        while (job_q.size() != 0) begin
            if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(1, 24);
            end
            j = job_q.pop_front();
            on_bus.push_back(j);
            in_ch.valid   <= 1'b1;
            in_ch.in_byte <= j.value;
            @(posedge i_clk);
            while (in_ch.ready !== 1'b1) @(posedge i_clk);
            burst--;
        end
        in_ch.valid <= 1'b0;
    endtask

    // Wait for the block to go idle, then write one register
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (due_words.size() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_FILTER_MODE) cfg_live.filter_mode = data[0];
        else cfg_live.replacement_byte = data[7:0];
    endtask

    // Receiver: random ready patterns, some stall-free, plus a long hold on request
    initial begin : rx_side
        logic [15:0] pat;
        forever begin
            if (holds_done != holds_asked) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end else begin
                pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                  : (16'($urandom) | 16'($urandom));
                for (int k = 0; k < 16; k++) begin
                    out_ch.ready <= pat[k];
                    @(posedge i_clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: predict on accepted input words, check accepted result words
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_job    j;
        t_group  grp;
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                j = on_bus.pop_front();
                decode_byte(in_ch.in_byte, grp);
                if (j.typed) begin
                    grp.count   = j.want_cnt;
                    grp.item[0] = j.want;
                end
                for (int k = 0; k < int'(grp.count); k++) due_words.push_back(grp.item[k]);
                n_bytes_in++;
            end
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got = '{out_byte: out_ch.out_byte, end_of_string: out_ch.end_of_string,
                        string_valid: out_ch.string_valid};
                n_words_out++;
                if (got.end_of_string === 1'b1) n_terms++;
                if (due_words.size() == 0) begin
                    $display("%0t: unexpected result word byte=%h eos=%b valid=%b",
                             $time, got.out_byte, got.end_of_string, got.string_valid);
                    fails++;
                end else begin
                    want = due_words.pop_front();
                    if (got.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want.out_byte, got.out_byte);
                        fails++;
                    end
                    if (got.end_of_string !== want.end_of_string) begin
                        $display("%0t: end_of_string expected %b actual %b",
                                 $time, want.end_of_string, got.end_of_string);
                        fails++;
                    end
                    if (got.string_valid !== want.string_valid) begin
                        $display("%0t: string_valid expected %b actual %b",
                                 $time, want.string_valid, got.string_valid);
                        fails++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no word moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles, %0d words still due",
                     $time, idle_cycles, due_words.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        t_row  dir_tab[$];
        t_byte repl;
        dir_tab = '{
            // filter off after reset: only terminators come out
            typed_row(8'h00, 3'd1, 8'h00, 1'b1, 1'b1),
            typed_row(8'h80, 3'd0, 8'h00, 1'b0, 1'b0),
            typed_row(8'h00, 3'd1, 8'h00, 1'b1, 1'b0),
            mode_row(8'h01),
            // ASCII top end and a bad lead at the byte maximum
            typed_row(8'h7F, 3'd1, 8'h7F, 1'b0, 1'b0),
            typed_row(8'hFF, 3'd1, REPLACEMENT_RESET, 1'b0, 1'b0),
            // good two byte sequence, then overlong C0 lead
            plain_row(8'hC3), plain_row(8'hA9),
            plain_row(8'hC0), plain_row(8'h80),
            // good three byte, surrogate, FFFE
            plain_row(8'hE2), plain_row(8'h82), plain_row(8'hAC),
            plain_row(8'hED), plain_row(8'hA0), plain_row(8'h80),
            plain_row(8'hEF), plain_row(8'hBF), plain_row(8'hBE),
            // four byte value past the code space
            plain_row(8'hF4), plain_row(8'h90), plain_row(8'h80), plain_row(8'h80),
            // break by ASCII, then break by the terminator
            plain_row(8'hC3), plain_row(8'h41),
            plain_row(8'hE2), plain_row(8'h00)
        };

        cfg_live = '{filter_mode: 1'b0, replacement_byte: REPLACEMENT_RESET};
        pd_held  = '{default: '0};
        pd_err   = 1'b0;
        drop_seq();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_MODE) begin
                send_jobs();
                apb_write(ADDR_FILTER_MODE, {31'd0, dir_tab[r].job.value[0]});
            end else begin
                job_q.push_back(dir_tab[r].job);
            end
        end
        send_jobs();

        // Random phases, each under its own settings; writes wait for idle
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            apb_write(ADDR_FILTER_MODE, (ph == 1) ? 32'd0 : 32'd1);
            case (ph)
                0:       repl = REPLACEMENT_RESET;
                1:       repl = 8'hFF;
                2:       repl = 8'h00;
                default: repl = t_byte'($urandom_range(1, 254));
            endcase
            apb_write(ADDR_REPLACEMENT, {24'd0, repl});
            // First phase: receiver holds off while bytes keep coming
            if (ph == 0) holds_asked++;
            while (job_q.size() < PHASE_BYTES) gen_token();
            if (ph == NUM_PHASES - 1) push_byte(8'h00);
            send_jobs();
        end

        // Drain and let the pipeline settle
        @(posedge i_clk);
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (due_words.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, due_words.size());
            fails++;
        end

        $display("Covered %0d input bytes and %0d result words (%0d terminators), %0d errors",
                 n_bytes_in, n_words_out, n_terms, fails);
        $display("Settings: filter on and off, replacement 00, 5F, FF and random; long hold");
        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/uvf_pkg.sv
sv/uvf_if.sv
sv/uvf_step.sv
sv/uvf_queue.sv
sv/utf8_validate_filter_top.sv
bench/tb_utf8_validate_filter_top.sv
